>>> src/pwbd_pkg.sv
`default_nettype none
package pwbd_pkg;

	localparam int COUNT_WIDTH = 8;
	localparam int OUT_TDATA_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 8;

	localparam logic [7:0] WINDOW_RESET = 8'd1;
	localparam logic [7:0] WRITE_THRESH_RESET = 8'd10;
	localparam logic [7:0] MODIFY_THRESH_RESET = 8'd20;
	localparam logic [3:0] FILE_LIMIT_RESET = 4'd10;
	localparam logic [7:0] MISMATCH_LIMIT_RESET = 8'd3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_WINDOW = 3'd0,
		REG_WRITE_THRESH = 3'd1,
		REG_MODIFY_THRESH = 3'd2,
		REG_FILE_LIMIT = 3'd3,
		REG_MISMATCH_LIMIT = 3'd4
	} reg_idx_t;

	typedef enum logic [8:0] {
		S_CLR = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_SCAN = 9'b000000100,
		S_RREQ = 9'b000001000,
		S_UPD = 9'b000010000,
		S_FSCAN = 9'b000100000,
		S_FCHK = 9'b001000000,
		S_FIN = 9'b010000000,
		S_OUT = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [7:0] window_seconds;
		logic [7:0] write_thresh;
		logic [7:0] modify_thresh;
		logic [3:0] file_thresh;
		logic [7:0] mismatch_limit;
	} cfg_t;

	typedef struct packed {
		logic       alarm;
		logic       table_full;
		logic [7:0] writes_seen;
		logic [7:0] modifies_seen;
		logic [3:0] files_seen;
		logic [7:0] mismatches_seen;
	} result_t;

	// table_full set, everything else zero
	localparam result_t FULL_RESULT = {1'b0, 1'b1, 28'd0};

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? 8'hFF : v + 8'd1;
	endfunction

endpackage
`default_nettype wire

>>> src/pwbd_ram.sv
`default_nettype none
module pwbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> src/pwbd_ctrl.sv
`default_nettype none
module pwbd_ctrl #(
	parameter int TABLE_ENTRIES = 256,
	parameter int FILES_PER_ENTRY = 15,
	parameter int FILE_ID_WIDTH = 32,
	parameter int PROCESS_ID_WIDTH = 22
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        opcode,
	input  wire logic [PROCESS_ID_WIDTH-1:0] process_id,
	input  wire logic [31:0]                 now_seconds,
	input  wire logic [1:0]                  event_mask,
	input  wire logic [FILE_ID_WIDTH-1:0]    file_id,
	input  wire logic                        file_known,
	input  wire logic                        header_bad,
	input  wire pwbd_pkg::cfg_t              cfg,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output pwbd_pkg::result_t                res
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(FILES_PER_ENTRY + 1);
	localparam int FAW = $clog2(TABLE_ENTRIES * FILES_PER_ENTRY);
	localparam int RW = CW + 57;
	localparam int LW = (CW > 4) ? CW : 4;
	localparam int OFS_CNT = 24;
	localparam int OFS_START = 24 + CW;

	pwbd_pkg::state_t state_q;

	logic                        op_q, known_q, bad_q;
	logic [PROCESS_ID_WIDTH-1:0] pid_q;
	logic [31:0]                 now_q;
	logic [1:0]                  mask_q;
	logic [FILE_ID_WIDTH-1:0]    fid_q;

	logic [IW-1:0]  clr_cnt_q, iss_cnt_q, addr_s1, free_idx_q, idx_q;
	logic           iss_on_q, chk_s1, free_found_q, alloc_q;
	logic [7:0]     w_wr_q, w_mod_q, w_mis_q;
	logic [CW-1:0]  w_cnt_q, k_q;
	logic [31:0]    w_start_q;
	logic [FAW-1:0] base_q;
	pwbd_pkg::result_t res_q;

	// memories
	logic                        pid_we;
	logic [IW-1:0]               pid_addr;
	logic [PROCESS_ID_WIDTH-1:0] pid_wdata, pid_rd;
	logic                        rec_we;
	logic [RW-1:0]               rec_wdata, rec_rd;
	logic                        f_we;
	logic [FAW-1:0]              f_addr;
	logic [FILE_ID_WIDTH-1:0]    f_rd;

	pwbd_ram #(.WIDTH(PROCESS_ID_WIDTH), .DEPTH(TABLE_ENTRIES)) u_pid_ram (
		.clk(clk), .we(pid_we), .addr(pid_addr), .wdata(pid_wdata), .rdata(pid_rd)
	);
	pwbd_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
		.clk(clk), .we(rec_we), .addr(idx_q), .wdata(rec_wdata), .rdata(rec_rd)
	);
	pwbd_ram #(.WIDTH(FILE_ID_WIDTH), .DEPTH(TABLE_ENTRIES * FILES_PER_ENTRY)) u_file_ram (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(fid_q), .rdata(f_rd)
	);

	// scan compare
	logic          hit_now, free_now, last_now, alloc_avail, alloc_wr;
	logic [IW-1:0] alloc_idx;

	assign hit_now = chk_s1 && (pid_rd == pid_q);
	assign free_now = chk_s1 && (pid_rd == '0);
	assign last_now = chk_s1 && (addr_s1 == IW'(TABLE_ENTRIES - 1));
	assign alloc_avail = free_found_q || free_now;
	assign alloc_idx = free_found_q ? free_idx_q : addr_s1;
	assign alloc_wr = (state_q == pwbd_pkg::S_SCAN) && !hit_now && last_now && alloc_avail;

	assign pid_we = (state_q == pwbd_pkg::S_CLR) || alloc_wr;
	assign pid_wdata = (state_q == pwbd_pkg::S_CLR) ? '0 : pid_q;
	always_comb begin
		if (state_q == pwbd_pkg::S_CLR) begin
			pid_addr = clr_cnt_q;
		end else if (alloc_wr) begin
			pid_addr = alloc_idx;
		end else begin
			pid_addr = iss_cnt_q;
		end
	end

	// stored entry, or a fresh one on allocation
	logic [7:0]    s_wr, s_mod, s_mis;
	logic [CW-1:0] s_cnt;
	logic [31:0]   s_start;
	logic          s_allowed, expire;

	always_comb begin
		if (alloc_q) begin
			s_wr = '0; s_mod = '0; s_mis = '0; s_cnt = '0;
			s_start = now_q; s_allowed = 1'b0;
		end else begin
			s_wr = rec_rd[7:0];
			s_mod = rec_rd[15:8];
			s_mis = rec_rd[23:16];
			s_cnt = rec_rd[OFS_CNT +: CW];
			s_start = rec_rd[OFS_START +: 32];
			s_allowed = rec_rd[RW-1];
		end
	end
	assign expire = (now_q - s_start) > 32'(cfg.window_seconds);

	// counts after the window check, before this event's increments
	logic [7:0] base_wr, base_mis;
	assign base_wr = expire ? 8'd0 : s_wr;
	assign base_mis = expire ? 8'd0 : s_mis;

	logic [7:0] fin_mod;
	logic       fin_alarm;
	assign fin_mod = mask_q[0] ? pwbd_pkg::sat_inc(w_mod_q) : w_mod_q;
	assign fin_alarm = (w_wr_q >= cfg.write_thresh) && (fin_mod >= cfg.modify_thresh)
		&& (LW'(w_cnt_q) >= LW'(cfg.file_thresh)) && (w_mis_q >= cfg.mismatch_limit);

	assign rec_we = ((state_q == pwbd_pkg::S_UPD) && op_q) || (state_q == pwbd_pkg::S_FIN);
	always_comb begin
		if (state_q == pwbd_pkg::S_FIN) begin
			rec_wdata = {1'b0, w_start_q, w_cnt_q, w_mis_q, fin_mod, w_wr_q};
		end else begin
			rec_wdata = {1'b1, s_start, s_cnt, s_mis, s_mod, s_wr};
		end
	end

	// file set walk: read and append share one address
	assign f_addr = base_q + FAW'(k_q);
	assign f_we = (state_q == pwbd_pkg::S_FSCAN) && (k_q == w_cnt_q)
		&& (w_cnt_q < CW'(FILES_PER_ENTRY));

	assign in_ready = (state_q == pwbd_pkg::S_IDLE);
	assign res_valid = (state_q == pwbd_pkg::S_OUT);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwbd_pkg::S_CLR;
			clr_cnt_q <= '0;
			iss_on_q <= 1'b0;
			chk_s1 <= 1'b0;
			free_found_q <= 1'b0;
			alloc_q <= 1'b0;
		end else begin
			unique case (state_q)
				pwbd_pkg::S_CLR: begin
					clr_cnt_q <= clr_cnt_q + IW'(1);
					if (clr_cnt_q == IW'(TABLE_ENTRIES - 1)) begin
						state_q <= pwbd_pkg::S_IDLE;
					end
				end
				pwbd_pkg::S_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						pid_q <= process_id;
						now_q <= now_seconds;
						mask_q <= event_mask;
						fid_q <= file_id;
						known_q <= file_known;
						bad_q <= header_bad;
						if (process_id == '0) begin
							res_q <= pwbd_pkg::FULL_RESULT;
							state_q <= pwbd_pkg::S_OUT;
						end else begin
							iss_cnt_q <= '0;
							iss_on_q <= 1'b1;
							chk_s1 <= 1'b0;
							free_found_q <= 1'b0;
							state_q <= pwbd_pkg::S_SCAN;
						end
					end
				end
				pwbd_pkg::S_SCAN: begin
					chk_s1 <= iss_on_q;
					addr_s1 <= iss_cnt_q;
					if (iss_on_q && !hit_now) begin
						if (iss_cnt_q == IW'(TABLE_ENTRIES - 1)) begin
							iss_on_q <= 1'b0;
						end else begin
							iss_cnt_q <= iss_cnt_q + IW'(1);
						end
					end
					if (free_now && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q <= addr_s1;
					end
					if (hit_now) begin
						idx_q <= addr_s1;
						alloc_q <= 1'b0;
						iss_on_q <= 1'b0;
						state_q <= pwbd_pkg::S_RREQ;
					end else if (last_now) begin
						if (alloc_avail) begin
							idx_q <= alloc_idx;
							alloc_q <= 1'b1;
							state_q <= pwbd_pkg::S_RREQ;
						end else begin
							res_q <= pwbd_pkg::FULL_RESULT;
							state_q <= pwbd_pkg::S_OUT;
						end
					end
				end
				pwbd_pkg::S_RREQ: begin
					base_q <= FAW'(idx_q) * FAW'(FILES_PER_ENTRY);
					state_q <= pwbd_pkg::S_UPD;
				end
				pwbd_pkg::S_UPD: begin
					if (op_q || s_allowed) begin
						res_q.alarm <= 1'b0;
						res_q.table_full <= 1'b0;
						res_q.writes_seen <= s_wr;
						res_q.modifies_seen <= s_mod;
						res_q.files_seen <= 4'(s_cnt);
						res_q.mismatches_seen <= s_mis;
						state_q <= pwbd_pkg::S_OUT;
					end else begin
						w_wr_q <= mask_q[1] ? pwbd_pkg::sat_inc(base_wr) : base_wr;
						w_mis_q <= (mask_q[1] && known_q && bad_q) ?
							pwbd_pkg::sat_inc(base_mis) : base_mis;
						w_mod_q <= expire ? 8'd0 : s_mod;
						w_cnt_q <= expire ? '0 : s_cnt;
						w_start_q <= expire ? now_q : s_start;
						k_q <= '0;
						if ((mask_q != 2'b00) && known_q) begin
							state_q <= pwbd_pkg::S_FSCAN;
						end else begin
							state_q <= pwbd_pkg::S_FIN;
						end
					end
				end
				pwbd_pkg::S_FSCAN: begin
					if (k_q == w_cnt_q) begin
						if (f_we) begin
							w_cnt_q <= w_cnt_q + CW'(1);
						end
						state_q <= pwbd_pkg::S_FIN;
					end else begin
						state_q <= pwbd_pkg::S_FCHK;
					end
				end
				pwbd_pkg::S_FCHK: begin
					if (f_rd == fid_q) begin
						state_q <= pwbd_pkg::S_FIN;
					end else begin
						k_q <= k_q + CW'(1);
						state_q <= pwbd_pkg::S_FSCAN;
					end
				end
				pwbd_pkg::S_FIN: begin
					res_q.alarm <= fin_alarm;
					res_q.table_full <= 1'b0;
					res_q.writes_seen <= w_wr_q;
					res_q.modifies_seen <= fin_mod;
					res_q.files_seen <= 4'(w_cnt_q);
					res_q.mismatches_seen <= w_mis_q;
					state_q <= pwbd_pkg::S_OUT;
				end
				pwbd_pkg::S_OUT: begin
					if (res_ready) begin
						state_q <= pwbd_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= pwbd_pkg::S_IDLE;
				end
			endcase
		end
	end

	a_full_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.table_full |-> !res.alarm && res.writes_seen == 8'd0)
		else $error("full result carries counts");
	a_no_append_past_cap: assert property (@(posedge clk) disable iff (!arst_n)
		f_we |-> w_cnt_q < CW'(FILES_PER_ENTRY))
		else $error("file set overflow");
	a_alloc_writes_pid: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_wr |=> alloc_q && state_q == pwbd_pkg::S_RREQ)
		else $error("allocation lost");
endmodule
`default_nettype wire

>>> src/per_process_write_burst_detector_top.sv
`default_nettype none
// Per-process write burst detector. Each accepted event beat looks up its process in a
// table kept in block RAM, allocating the lowest free entry if needed, clears the
// entry's counts when the window ran out, updates write/modify/mismatch counts and the
// entry's set of distinct file ids, and returns one result beat with the alarm flag.
// Opcode beats mark the entry allowed; they and beats for allowed entries only report
// its counts. Process id zero or a full table gives a table_full beat. The lookup walks
// the process RAM one entry per cycle, and the file check walks the file RAM one slot at
// a time via FSCAN and FCHK. One event is in flight at a time; a result waiting on the
// master side does not stall the next event's intake. After reset the block clears the
// process RAM before it takes its first event beat; configuration writes are taken at any time.
module per_process_write_burst_detector_top #(
	parameter int TABLE_ENTRIES = 256,
	parameter int FILES_PER_ENTRY = 15,
	parameter int FILE_ID_WIDTH = 32,
	parameter int PROCESS_ID_WIDTH = 22
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// process_id, now_seconds, event_mask, file_id, file_known, header_bad; zero pad
	input  wire logic [((PROCESS_ID_WIDTH + FILE_ID_WIDTH + 36 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// opcode
	input  wire logic [0:0] s_axis_tuser,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	// alarm, writes_seen, modifies_seen, files_seen, mismatches_seen; zero pad
	output logic [pwbd_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	// table_full
	output logic [0:0] m_axis_tuser,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [pwbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [pwbd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	localparam int P0 = PROCESS_ID_WIDTH;
	localparam int P1 = P0 + 32;
	localparam int P2 = P1 + 2;
	localparam int P3 = P2 + FILE_ID_WIDTH;

	pwbd_pkg::cfg_t    cfg_q;
	pwbd_pkg::result_t res, out_q;
	logic              res_valid, res_ready, out_valid_q;

	// Configuration registers: always ready, unknown indexes are dropped.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_seconds <= pwbd_pkg::WINDOW_RESET;
			cfg_q.write_thresh <= pwbd_pkg::WRITE_THRESH_RESET;
			cfg_q.modify_thresh <= pwbd_pkg::MODIFY_THRESH_RESET;
			cfg_q.file_thresh <= pwbd_pkg::FILE_LIMIT_RESET;
			cfg_q.mismatch_limit <= pwbd_pkg::MISMATCH_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (pwbd_pkg::reg_idx_t'(cfg_index))
				pwbd_pkg::REG_WINDOW: cfg_q.window_seconds <= cfg_data;
				pwbd_pkg::REG_WRITE_THRESH: cfg_q.write_thresh <= cfg_data;
				pwbd_pkg::REG_MODIFY_THRESH: cfg_q.modify_thresh <= cfg_data;
				pwbd_pkg::REG_FILE_LIMIT: cfg_q.file_thresh <= cfg_data[3:0];
				pwbd_pkg::REG_MISMATCH_LIMIT: cfg_q.mismatch_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pwbd_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FILES_PER_ENTRY(FILES_PER_ENTRY),
		.FILE_ID_WIDTH(FILE_ID_WIDTH),
		.PROCESS_ID_WIDTH(PROCESS_ID_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.opcode(s_axis_tuser[0]),
		.process_id(s_axis_tdata[P0-1:0]),
		.now_seconds(s_axis_tdata[P1-1:P0]),
		.event_mask(s_axis_tdata[P2-1:P1]),
		.file_id(s_axis_tdata[P3-1:P2]),
		.file_known(s_axis_tdata[P3]),
		.header_bad(s_axis_tdata[P3+1]),
		.cfg(cfg_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Output register: hold the beat until the sink takes it, refill on the same edge.
	assign res_ready = !out_valid_q || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_q.table_full;
	assign m_axis_tdata = {3'b000, out_q.mismatches_seen, out_q.files_seen,
		out_q.modifies_seen, out_q.writes_seen, out_q.alarm};
endmodule
`default_nettype wire

>>> tb/pwbd_checker.sv
`default_nettype none
module pwbd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,
	input  wire logic [0:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic [0:0]  m_axis_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               fails,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPROC = 256;
	localparam int NFILE = 15;

	pwbd_pkg::cfg_t limits;
	logic [21:0] proc_tag [NPROC];
	logic [7:0]  proc_writes [NPROC];
	logic [7:0]  proc_modifies [NPROC];
	logic [7:0]  proc_mism [NPROC];
	logic [3:0]  proc_nfiles [NPROC];
	logic [31:0] proc_start [NPROC];
	logic        proc_allowed [NPROC];
	logic [31:0] proc_fileset [NPROC][NFILE];
	pwbd_pkg::result_t due_reports [$];

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// lookup or allocate the lowest free slot; -1 when the table is full
	function automatic int locate(input logic [21:0] pid, input logic [31:0] now);
		for (int i = 0; i < NPROC; i++)
			if (proc_tag[i] == pid) return i;
		for (int i = 0; i < NPROC; i++) begin
			if (proc_tag[i] == '0) begin
				proc_tag[i] = pid;
				proc_writes[i] = '0;
				proc_modifies[i] = '0;
				proc_mism[i] = '0;
				proc_nfiles[i] = '0;
				proc_start[i] = now;
				proc_allowed[i] = 1'b0;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void note_file(input int e, input logic [31:0] fid);
		int n;
		n = proc_nfiles[e];
		for (int k = 0; k < n; k++)
			if (proc_fileset[e][k] == fid) return;
		if (n < NFILE) begin
			proc_fileset[e][n] = fid;
			proc_nfiles[e] = 4'(n + 1);
		end
	endfunction

	function automatic pwbd_pkg::result_t score_event(input logic [95:0] d, input logic op);
		logic [21:0] pid;
		logic [31:0] now, fid;
		logic [1:0]  mask;
		logic        known, bad;
		int          e;
		pwbd_pkg::result_t r;
		pid = d[21:0];
		now = d[53:22];
		mask = d[55:54];
		fid = d[87:56];
		known = d[88];
		bad = d[89];
		r = '0;
		e = (pid != '0) ? locate(pid, now) : -1;
		if (e < 0) begin
			r.table_full = 1'b1;
			return r;
		end
		if (op) begin
			proc_allowed[e] = 1'b1;
		end else if (!proc_allowed[e]) begin
			if (now - proc_start[e] > {24'd0, limits.window_seconds}) begin
				proc_writes[e] = '0;
				proc_modifies[e] = '0;
				proc_mism[e] = '0;
				proc_nfiles[e] = '0;
				proc_start[e] = now;
			end
			if (mask[1]) begin
				proc_writes[e] = bump(proc_writes[e]);
				if (known && bad) proc_mism[e] = bump(proc_mism[e]);
			end
			if (mask != 2'b00 && known) note_file(e, fid);
			if (mask[0]) proc_modifies[e] = bump(proc_modifies[e]);
			r.alarm = proc_writes[e] >= limits.write_thresh &&
				proc_modifies[e] >= limits.modify_thresh &&
				proc_nfiles[e] >= limits.file_thresh &&
				proc_mism[e] >= limits.mismatch_limit;
		end
		r.writes_seen = proc_writes[e];
		r.modifies_seen = proc_modifies[e];
		r.files_seen = proc_nfiles[e];
		r.mismatches_seen = proc_mism[e];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pwbd_pkg::result_t want;
		if (!arst_n) begin
			limits.window_seconds = pwbd_pkg::WINDOW_RESET;
			limits.write_thresh = pwbd_pkg::WRITE_THRESH_RESET;
			limits.modify_thresh = pwbd_pkg::MODIFY_THRESH_RESET;
			limits.file_thresh = pwbd_pkg::FILE_LIMIT_RESET;
			limits.mismatch_limit = pwbd_pkg::MISMATCH_LIMIT_RESET;
			for (int i = 0; i < NPROC; i++) proc_tag[i] = '0;
			due_reports.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (pwbd_pkg::reg_idx_t'(cfg_index))
					pwbd_pkg::REG_WINDOW: limits.window_seconds = cfg_data;
					pwbd_pkg::REG_WRITE_THRESH: limits.write_thresh = cfg_data;
					pwbd_pkg::REG_MODIFY_THRESH: limits.modify_thresh = cfg_data;
					pwbd_pkg::REG_FILE_LIMIT: limits.file_thresh = cfg_data[3:0];
					pwbd_pkg::REG_MISMATCH_LIMIT: limits.mismatch_limit = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				due_reports.push_back(score_event(s_axis_tdata, s_axis_tuser[0]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_reports.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
					fails++;
				end else begin
					want = due_reports.pop_front();
					check_field("alarm", 8'(want.alarm), 8'(m_axis_tdata[0]));
					check_field("table_full", 8'(want.table_full), 8'(m_axis_tuser[0]));
					check_field("writes_seen", want.writes_seen, m_axis_tdata[8:1]);
					check_field("modifies_seen", want.modifies_seen, m_axis_tdata[16:9]);
					check_field("files_seen", 8'(want.files_seen), 8'(m_axis_tdata[20:17]));
					check_field("mismatches_seen", want.mismatches_seen,
						m_axis_tdata[28:21]);
				end
			end
			pending = due_reports.size();
		end
	end
endmodule
`default_nettype wire

>>> tb/per_process_write_burst_detector_top_tb.sv
`default_nettype none
module per_process_write_burst_detector_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// longest quiet stretch: one event behind the long hold-off, many times over
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// process_id, now_seconds, event_mask, file_id, file_known, header_bad; zero pad
	logic [95:0] s_axis_tdata = '0;
	// opcode
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// alarm, writes_seen, modifies_seen, files_seen, mismatches_seen; zero pad
	logic [31:0] m_axis_tdata;
	// table_full
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	int fails, pending;
	int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
	logic hold_go = 1'b0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int quiet = 0;

	logic [31:0] clock_now = 32'd100;
	logic [21:0] hot_pid [6];
	logic [31:0] file_pool [20];

	always #5 clk = ~clk;

	per_process_write_burst_detector_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pwbd_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	// Result side: stall at random per mode; once asked, hold off for a long stretch
	// so the block backs up and drops s_axis_tready.
	always @(posedge clk) begin
		if (hold_go && !hold_done && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_mode == 2)
			m_axis_tready <= ($urandom_range(99) >= 57);
		else if (idle_mode == 3)
			m_axis_tready <= ($urandom_range(99) >= 31);
		else
			m_axis_tready <= 1'b1;
	end

	// Watchdog: count cycles in which no beat moves on any channel.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one event beat; called and returning at a rising edge, valid left high.
	task automatic send_event(input logic op, input logic [21:0] pid, input logic [31:0] now,
			input logic [1:0] mask, input logic [31:0] fid, input logic known,
			input logic bad);
		int gap;
		gap = 0;
		if ((idle_mode == 1 && $urandom_range(99) < 57) ||
				(idle_mode == 3 && $urandom_range(99) < 31))
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, bad, known, fid, mask, now, pid};
		// ready is stable away from the rising edge; sample it at the falling one
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	// Hold the sender until every result is back, then let the block settle.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		// the count settles between edges; sample it at the falling one
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input pwbd_pkg::reg_idx_t idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [7:0] win, input logic [7:0] wr,
			input logic [7:0] md, input logic [7:0] fl, input logic [7:0] mm);
		write_reg(pwbd_pkg::REG_WINDOW, win);
		write_reg(pwbd_pkg::REG_WRITE_THRESH, wr);
		write_reg(pwbd_pkg::REG_MODIFY_THRESH, md);
		write_reg(pwbd_pkg::REG_FILE_LIMIT, fl);
		write_reg(pwbd_pkg::REG_MISMATCH_LIMIT, mm);
	endtask

	// Fresh burst sources and file pool for a phase.
	task automatic new_pools;
		for (int i = 0; i < 6; i++) hot_pid[i] = 22'($urandom_range(1, 22'h3FFFFF));
		for (int i = 0; i < 20; i++) file_pool[i] = $urandom;
	endtask

	// Mostly bursts from a few processes touching a shared file pool; the rest noise.
	task automatic random_event;
		int pick;
		logic [21:0] pid;
		logic [31:0] fid;
		pick = $urandom_range(99);
		if (pick < 70) pid = hot_pid[$urandom_range(5)];
		else if (pick < 74) pid = '0;
		else pid = 22'($urandom_range(1, 22'h3FFFFF));
		pick = $urandom_range(99);
		if (pick < 10) clock_now = clock_now + $urandom_range(1, 3);
		else if (pick < 14) clock_now = clock_now + $urandom_range(4, 300);
		else if (pick < 16) clock_now = $urandom;
		fid = ($urandom_range(99) < 60) ? file_pool[$urandom_range(19)] : $urandom;
		send_event($urandom_range(99) < 2, pid, clock_now, 2'($urandom_range(3)), fid,
			$urandom_range(99) < 85, $urandom_range(99) < 40);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, wrap of time, allowed marking, zero id, unknown file
		send_event(1'b0, 22'd1, 32'd0, 2'b00, 32'd0, 1'b0, 1'b0);
		send_event(1'b0, 22'h3FFFFF, 32'hFFFFFFFF, 2'b11, 32'hFFFFFFFF, 1'b1, 1'b1);
		send_event(1'b0, 22'h3FFFFF, 32'd0, 2'b10, 32'h0, 1'b1, 1'b1);
		send_event(1'b0, 22'h3FFFFF, 32'd1, 2'b01, 32'h0, 1'b1, 1'b1);
		send_event(1'b0, 22'h3FFFFF, 32'd5, 2'b11, 32'h12345678, 1'b0, 1'b1);
		send_event(1'b0, 22'h3FFFFF, 32'd5, 2'b10, 32'h12345678, 1'b1, 1'b0);
		send_event(1'b0, 22'h3FFFFF, 32'd6, 2'b00, 32'hABCD0000, 1'b1, 1'b1);
		send_event(1'b0, 22'd0, 32'd6, 2'b11, 32'h1, 1'b1, 1'b1);
		send_event(1'b1, 22'd0, 32'd6, 2'b00, 32'h1, 1'b1, 1'b1);
		send_event(1'b1, 22'd1, 32'd7, 2'b00, 32'h0, 1'b0, 1'b0);
		send_event(1'b0, 22'd1, 32'd7, 2'b11, 32'h55, 1'b1, 1'b1);
		send_event(1'b1, 22'h2AAAAA, 32'd7, 2'b11, 32'h55, 1'b1, 1'b1);
		send_event(1'b0, 22'h2AAAAA, 32'd8, 2'b11, 32'h55, 1'b1, 1'b1);
		for (int i = 0; i < 7; i++)
			send_event(1'b0, 22'h155555, 32'd10, 2'b11, 32'hF0 + i, 1'b1, 1'b1);
		drain();

		// alarm on for every counted event: all limits zero, any elapsed second restarts the window
		idle_mode <= 1;
		set_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		new_pools();
		repeat (150) random_event();
		drain();

		// widest window, unreachable limits, full file sets
		idle_mode <= 2;
		set_limits(8'd255, 8'd255, 8'd255, 8'd15, 8'd255);
		new_pools();
		repeat (150) random_event();
		drain();

		// reachable limits; hold off the result side mid-phase
		idle_mode <= 3;
		set_limits(8'd20, 8'd3, 8'd4, 8'd4, 8'd2);
		new_pools();
		repeat (60) random_event();
		hold_go <= 1'b1;
		repeat (90) random_event();
		drain();

		idle_mode <= 0;
		set_limits(8'd5, 8'd2, 8'd2, 8'd3, 8'd1);
		new_pools();
		repeat (150) random_event();
		drain();

		// exhaust the table with new processes, then keep going against a full table
		idle_mode <= 3;
		set_limits(8'd1, 8'd10, 8'd20, 8'd10, 8'd3);
		for (int k = 0; k < 280; k++)
			send_event(1'b0, 22'(3000000 + k), clock_now, 2'b00, 32'd0, 1'b0, 1'b0);
		repeat (40) random_event();
		drain();

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
